// File: rtl/core/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, command codes and the command word between the front and
// back parts of the stack pop sequence checker.
// ----------------------------------------------------------------------------
package spsc_pkg;

	localparam int MAX_CARS = 1024;
	localparam int CAR_W    = 11;
	localparam int LEN_W    = 11;
	localparam int IDX_W    = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
	localparam int DEPTH_W  = $clog2(MAX_CARS + 1);
	localparam int NA_W     = CAR_W + 1;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_FAIL = 2'd2
	} cmd_kind_t;

	// For a push, lo is the first value to park and val is one past the last.
	// For a pop, val is the value that must be on top of the siding.
	// Values are car numbers minus one.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [CAR_W-1:0]   lo;
		logic [CAR_W-1:0]   val;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic failed;
	} back_status_t;

endpackage

// File: rtl/core/stack_pop_sequence_checker_unit.sv
// ----------------------------------------------------------------------------
// stack_pop_sequence_checker_unit
// Decides whether a departure order of cars can be produced through one
// stack siding, one car word per input and one verdict per sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive car and raise push; a word is taken when full is low.
//   Result queue: while empty is low, possible holds the verdict of the oldest
//   finished sequence; raise pop to take it.
//   Config: cfg_valid with sequence_length writes the cars per sequence
//   (cfg_ready is always high). A value of 0 acts as 1 and values above the
//   siding capacity act as the capacity. Write it only while the block is idle.
//   A verdict word follows only the last car of each sequence.
// Timing:
//   A car that passes straight through or fails is handled in the idle state
//   of the back part; a car that parks earlier cars then stays in the push
//   state, parking one car per cycle; a pop that leaves cars below it also
//   passes the pop-read state (registered stack read). Parks in a sequence
//   total fewer than its length. The last car passes the command queue, and
//   the verdict is registered in the back part before it reaches the ports.
// Reset and stalls:
//   Reset empties both queues, sets the length to 1 and clears the sequence.
//   If the result is not popped, the back part holds before a sequence's last
//   command while the two-entry command queue keeps taking cars until full.
// ----------------------------------------------------------------------------
module stack_pop_sequence_checker_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [spsc_pkg::LEN_W-1:0] sequence_length,
	input  logic                       push,
	output logic                       full,
	input  logic [spsc_pkg::CAR_W-1:0] car,
	output logic                       empty,
	input  logic                       pop,
	output logic                       possible
);
	import spsc_pkg::*;

	cmd_t         wr_cmd;
	cmd_t         rd_cmd;
	logic         cmd_wr;
	logic         cmd_rd;
	logic         cmd_full;
	logic         cmd_empty;
	logic         res_valid;
	back_status_t back_st;

	spsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.sequence_length (sequence_length),
		.push            (push),
		.car             (car),
		.cmd_full        (cmd_full),
		.cmd_wr          (cmd_wr),
		.cmd_data        (wr_cmd)
	);

	spsc_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (wr_cmd),
		.rd_en   (cmd_rd),
		.rd_data (rd_cmd),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	spsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (rd_cmd),
		.cmd_rd       (cmd_rd),
		.res_pop      (pop),
		.res_valid    (res_valid),
		.res_possible (possible),
		.status       (back_st)
	);

	assign full  = cmd_full;
	assign empty = !res_valid;

	// A full command queue can never also read as empty.
	a_fifo_flags: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_full |-> !cmd_empty)
		else $error("command queue full and empty at once");

	// An accepted word is still queued in the next cycle.
	a_word_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted word lost from command queue");

	// A verdict appears only when the back part had a command to finish.
	a_verdict_src: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(!cmd_empty || back_st.busy))
		else $error("verdict issued without a command");

	// The failure flag is set only when the back part had a command to work on.
	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(back_st.failed && !back_st.busy) |-> $past(back_st.failed || !cmd_empty
			|| back_st.busy))
		else $error("failure flag set without a command");

endmodule

// File: rtl/core/spsc_front.sv
// ----------------------------------------------------------------------------
// spsc_front
// Holds the length register and the arrival bookkeeping, and turns each
// accepted car word into a push, pop or fail command for the back part.
// ----------------------------------------------------------------------------
module spsc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [spsc_pkg::LEN_W-1:0] sequence_length,
	input  logic                    push,
	input  logic [spsc_pkg::CAR_W-1:0] car,
	input  logic                    cmd_full,
	output logic                    cmd_wr,
	output spsc_pkg::cmd_t          cmd_data
);
	import spsc_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_eff;
	logic [NA_W-1:0]  next_arr_q;
	logic [LEN_W-1:0] items_q;
	logic [LEN_W:0]   items_inc;
	logic             bad;
	logic             is_push;
	logic             last;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(len_q) > MAX_CARS) begin
			len_eff = LEN_W'(MAX_CARS);
		end else begin
			len_eff = len_q;
		end
	end

	assign bad       = (car == '0) || (car > len_eff);
	assign is_push   = NA_W'(car) >= next_arr_q;
	assign items_inc = (LEN_W+1)'(items_q) + (LEN_W+1)'(1);
	assign last      = items_inc >= (LEN_W+1)'(len_eff);
	assign cmd_wr    = push && !cmd_full;

	always_comb begin
		cmd_data.lo   = CAR_W'(next_arr_q - NA_W'(1));
		cmd_data.val  = car - CAR_W'(1);
		cmd_data.last = last;
		if (bad) begin
			cmd_data.kind = CMD_FAIL;
		end else if (is_push) begin
			cmd_data.kind = CMD_PUSH;
		end else begin
			cmd_data.kind = CMD_POP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= LEN_W'(1);
			next_arr_q <= NA_W'(1);
			items_q    <= '0;
		end else begin
			if (cfg_valid) begin
				len_q <= sequence_length;
			end
			if (cmd_wr) begin
				if (last) begin
					items_q    <= '0;
					next_arr_q <= NA_W'(1);
				end else begin
					items_q <= LEN_W'(items_inc);
					if (!bad && is_push) begin
						next_arr_q <= NA_W'(car) + NA_W'(1);
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/spsc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// spsc_cmd_fifo
// Two-entry command queue that lets the front and back parts stall
// independently.
// ----------------------------------------------------------------------------
module spsc_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  spsc_pkg::cmd_t wr_data,
	input  logic           rd_en,
	output spsc_pkg::cmd_t rd_data,
	output logic           full,
	output logic           empty
);
	import spsc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/spsc_back.sv
// ----------------------------------------------------------------------------
// spsc_back
// Carries out the commands on the siding stack: parks one car per cycle,
// checks and pops the top, tracks failure and issues the verdict.
// ----------------------------------------------------------------------------
module spsc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_empty,
	input  spsc_pkg::cmd_t         cmd,
	output logic                   cmd_rd,
	input  logic                   res_pop,
	output logic                   res_valid,
	output logic                   res_possible,
	output spsc_pkg::back_status_t status
);
	import spsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PUSH  = 3'b010,
		ST_POPRD = 3'b100
	} state_t;

	state_t             state_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [CAR_W-1:0]   top_q;
	logic [CAR_W-1:0]   cur_q;
	logic [CAR_W-1:0]   hi_q;
	logic               last_q;
	logic               failed_q;
	logic               valid_q;
	logic               possible_q;

	logic [IDX_W-1:0]   stack_mem [MAX_CARS];
	logic [IDX_W-1:0]   rd_q;
	logic [IDX_W-1:0]   wr_idx;
	logic [IDX_W-1:0]   rd_idx;

	logic               take;
	logic               hit;
	logic               fin;
	logic               fin_last;
	logic               fin_fail;
	logic               seq_end;

	// A last command is taken only while the result slot is free, so the
	// slot stays free until that command finishes.
	assign take    = (state_q == ST_IDLE) && !cmd_empty && (!cmd.last || !valid_q);
	assign cmd_rd  = take;
	assign hit     = (depth_q != '0) && (top_q == cmd.val);
	assign wr_idx  = IDX_W'(depth_q - DEPTH_W'(1));
	assign rd_idx  = IDX_W'(depth_q - DEPTH_W'(2));
	assign seq_end = fin && fin_last;

	always_comb begin
		fin      = 1'b0;
		fin_last = last_q;
		fin_fail = failed_q;
		case (state_q)
			ST_IDLE: begin
				fin_last = cmd.last;
				if (take) begin
					if (failed_q) begin
						fin = 1'b1;
					end else begin
						case (cmd.kind)
							CMD_PUSH: fin = !(cmd.lo < cmd.val);
							CMD_POP: begin
								if (!hit) begin
									fin      = 1'b1;
									fin_fail = 1'b1;
								end else begin
									fin = depth_q == DEPTH_W'(1);
								end
							end
							default: begin
								fin      = 1'b1;
								fin_fail = 1'b1;
							end
						endcase
					end
				end
			end
			ST_PUSH:  fin = CAR_W'(cur_q + CAR_W'(1)) == hi_q;
			ST_POPRD: fin = 1'b1;
			default:  fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && depth_q != '0) begin
			stack_mem[wr_idx] <= IDX_W'(top_q);
		end
		rd_q <= stack_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			depth_q    <= '0;
			failed_q   <= 1'b0;
			valid_q    <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (res_pop && valid_q) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take && !failed_q) begin
						last_q <= cmd.last;
						if (cmd.kind == CMD_PUSH && cmd.lo < cmd.val) begin
							state_q <= ST_PUSH;
						end else if (cmd.kind == CMD_POP && hit) begin
							if (!seq_end) begin
								depth_q <= depth_q - DEPTH_W'(1);
							end
							if (depth_q != DEPTH_W'(1)) begin
								state_q <= ST_POPRD;
							end
						end
					end
				end
				ST_PUSH: begin
					if (!seq_end) begin
						depth_q <= depth_q + DEPTH_W'(1);
					end
					if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_POPRD: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
			if (fin) begin
				if (fin_last) begin
					depth_q  <= '0;
					failed_q <= 1'b0;
					valid_q  <= 1'b1;
				end else begin
					failed_q <= fin_fail;
				end
			end
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= cmd.lo;
			hi_q  <= cmd.val;
		end else if (state_q == ST_PUSH) begin
			cur_q <= CAR_W'(cur_q + CAR_W'(1));
		end
		if (state_q == ST_PUSH) begin
			top_q <= cur_q;
		end else if (state_q == ST_POPRD) begin
			top_q <= CAR_W'(rd_q);
		end
		if (fin && fin_last) begin
			possible_q <= !fin_fail;
		end
	end

	assign res_valid     = valid_q;
	assign res_possible  = possible_q;
	assign status.busy   = state_q != ST_IDLE;
	assign status.failed = failed_q;

endmodule

// File: tb/sv/stack_pop_sequence_checker_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_pop_sequence_checker_unit_test
// Feeds departure orders of cars into the checker and compares every verdict
// word with a siding model kept here. Directed orders cover the length and
// car extremes, out-of-range cars, early failures and the deepest park; the
// random part mixes achievable orders with broken ones at many lengths,
// under random idling on both queues and one long result hold-off.
// ----------------------------------------------------------------------------
module stack_pop_sequence_checker_unit_test;

	import spsc_pkg::*;

	localparam int RANDOM_CARS   = 220;
	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int CALM_START    = 3000;
	localparam int CALM_END      = 4500;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LEN_W-1:0]     sequence_length = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [CAR_W-1:0]     car = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 possible;

	stack_pop_sequence_checker_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.sequence_length (sequence_length),
		.push            (push),
		.full            (full),
		.car             (car),
		.empty           (empty),
		.pop             (pop),
		.possible        (possible)
	);

	// Siding model.
	logic [LEN_W-1:0] length_reg = 11'd1;
	int unsigned      next_car = 1;
	int unsigned      park_depth = 0;
	int unsigned      seq_count = 0;
	bit               seq_failed = 1'b0;
	logic [IDX_W-1:0] siding [MAX_CARS];
	bit               pending_verdicts [$];

	logic [CAR_W-1:0] car_backlog [$];
	int               cars_queued = 0;
	int               cars_taken = 0;
	int               results_taken = 0;
	int               error_count = 0;
	int               cycle_count = 0;
	int               stall_count = 0;
	int               hold_left = 0;
	bit               hold_done = 1'b0;
	bit               car_taken = 1'b0;

	wire calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void advance_siding(input logic [CAR_W-1:0] c);
		int unsigned len;
		len = (length_reg == 0) ? 1 : ((length_reg > MAX_CARS) ? MAX_CARS : length_reg);
		if (!seq_failed) begin
			if (c == 0 || c > len) begin
				seq_failed = 1'b1;
			end else if (c >= next_car) begin
				// Every earlier car that has not arrived is parked on the siding.
				while (next_car < c && park_depth < MAX_CARS) begin
					siding[park_depth] = IDX_W'(next_car - 1);
					park_depth++;
					next_car++;
				end
				next_car = c + 1;
			end else if (park_depth > 0 && int'(siding[park_depth - 1]) + 1 == int'(c)) begin
				park_depth--;
			end else begin
				seq_failed = 1'b1;
			end
		end
		seq_count++;
		if (seq_count >= len) begin
			pending_verdicts.insert(pending_verdicts.size(), !seq_failed);
			next_car = 1;
			park_depth = 0;
			seq_count = 0;
			seq_failed = 1'b0;
		end
	endfunction

	function automatic void queue_car(input logic [CAR_W-1:0] c);
		car_backlog.insert(car_backlog.size(), c);
		cars_queued++;
	endfunction

	// Builds one order of len cars by running the siding forward; a broken
	// order is then damaged in one of several ways.
	task automatic queue_sequence(input int unsigned len, input bit well_formed);
		logic [CAR_W-1:0] order [$];
		logic [CAR_W-1:0] parked [$];
		logic [CAR_W-1:0] tmp;
		int unsigned      arrive;
		int unsigned      a;
		int unsigned      b;
		arrive = 1;
		while (order.size() < len) begin
			if (arrive <= len && (parked.size() == 0 || $urandom_range(0, 1))) begin
				parked.insert(parked.size(), CAR_W'(arrive));
				arrive++;
			end else begin
				order.insert(order.size(), parked.pop_back());
			end
		end
		if (!well_formed) begin
			case ($urandom_range(0, 3))
				0: begin
					a = $urandom_range(0, len - 1);
					b = $urandom_range(0, len - 1);
					tmp = order[a];
					order[a] = order[b];
					order[b] = tmp;
				end
				1: begin
					order[$urandom_range(0, len - 1)] = CAR_W'($urandom_range(0, 2047));
				end
				2: begin
					foreach (order[i]) begin
						order[i] = CAR_W'($urandom_range(0, 3) == 0 ?
							$urandom_range(0, 2047) : $urandom_range(1, len));
					end
				end
				default: begin
					for (a = len - 1; a > 0; a--) begin
						b = $urandom_range(0, a);
						tmp = order[a];
						order[a] = order[b];
						order[b] = tmp;
					end
				end
			endcase
		end
		foreach (order[i]) begin
			queue_car(order[i]);
		end
	endtask

	task automatic wait_idle();
		while (cars_taken != cars_queued || pending_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		sequence_length <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sampling, prediction, checking and the watchdog.
	always @(posedge clk) begin
		cycle_count++;
		car_taken = arst_n && push && !full;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				length_reg = sequence_length;
				stall_count = 0;
			end else begin
				stall_count++;
			end
			if (car_taken) begin
				advance_siding(car);
				cars_taken++;
				stall_count = 0;
			end
			if (pop && !empty) begin
				results_taken++;
				stall_count = 0;
				if (pending_verdicts.size() == 0) begin
					$error("possible: expected no word, actual %0d", possible);
					error_count++;
				end else if (possible !== pending_verdicts[0]) begin
					$error("possible: expected %0d, actual %0d", pending_verdicts[0], possible);
					error_count++;
					void'(pending_verdicts.pop_front());
				end else begin
					void'(pending_verdicts.pop_front());
				end
			end
			if (stall_count >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Car driver: a word stays on the port until it is taken.
	always @(negedge clk) begin
		if (arst_n && !(push && !car_taken)) begin
			if (car_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
				car <= car_backlog.pop_front();
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Verdict reader, with one long hold-off while cars keep coming.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && results_taken > 11 && car_backlog.size() > 20) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= 15);
			end
		end
	end

	initial begin
		int          random_cars;
		int unsigned roll;
		int unsigned eff;
		int unsigned nseq;
		logic [LEN_W-1:0] cfg_value;
		random_cars = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Length left at its reset value of one.
		queue_car(11'd1);
		queue_car(11'd0);
		queue_car(11'd2047);
		queue_car(11'd2);
		wait_idle();

		// A length of zero acts as one.
		write_length(11'd0);
		queue_car(11'd1);
		queue_car(11'd1024);
		wait_idle();

		write_length(11'd3);
		queue_car(11'd3); queue_car(11'd2); queue_car(11'd1);
		queue_car(11'd2); queue_car(11'd3); queue_car(11'd1);
		// The wrong car is on top of the siding.
		queue_car(11'd3); queue_car(11'd1); queue_car(11'd2);
		// A repeated car that has already left.
		queue_car(11'd1); queue_car(11'd1); queue_car(11'd2);
		// Words after a failure are consumed without effect.
		queue_car(11'd0); queue_car(11'd2047); queue_car(11'd5);
		wait_idle();

		// Oversized length clamps to the siding capacity; the first car parks
		// all the others.
		write_length(11'd2047);
		for (int c = MAX_CARS; c >= 1; c--) begin
			queue_car(CAR_W'(c));
		end
		wait_idle();

		while (random_cars < RANDOM_CARS) begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				cfg_value = 11'd0;
			end else if (roll < 70) begin
				cfg_value = LEN_W'($urandom_range(1, 8));
			end else if (roll < 93) begin
				cfg_value = LEN_W'($urandom_range(9, 40));
			end else begin
				cfg_value = LEN_W'($urandom_range(41, 100));
			end
			write_length(cfg_value);
			eff = (cfg_value == 0) ? 1 : cfg_value;
			nseq = 1 + $urandom_range(0, 120 / eff);
			repeat (nseq) begin
				queue_sequence(eff, $urandom_range(0, 99) < 70);
				random_cars += eff;
			end
			wait_idle();
		end

		wait_idle();
		repeat (20) @(negedge clk);
		if (error_count == 0 && pending_verdicts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: stack_pop_sequence_checker_unit.f
rtl/core/spsc_pkg.sv
rtl/core/spsc_front.sv
rtl/core/spsc_cmd_fifo.sv
rtl/core/spsc_back.sv
rtl/core/stack_pop_sequence_checker_unit.sv
tb/sv/stack_pop_sequence_checker_unit_test.sv
